[sv/piaw_pkg.sv]
// Package for the PI controller: widths, microcode types, control ROM and saturation helper.
package piaw_pkg;

    // Data format.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TIME_FRAC  = 16;
    localparam int GAIN_W     = 24;
    localparam int LIM_W      = 31;

    // Derived datapath widths.
    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int MB_W   = GAIN_W + 1;
    localparam int PROD_W = ERR_W + MB_W;
    localparam int CMP_W  = ((ERR_W > LIM_W + 1) ? ERR_W : LIM_W + 1) + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIM  = 2'd2;

    // Operation codes of an input word.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_PRESET = 1'b1;

    // Sequencer step counter.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_MUL_KP     = 4'd0;
    localparam t_step STEP_LD_PROP    = 4'd1;
    localparam t_step STEP_LD_P1      = 4'd2;
    localparam t_step STEP_MUL_DT     = 4'd3;
    localparam t_step STEP_SUM_INC    = 4'd4;
    localparam t_step STEP_CLAMP_INC  = 4'd5;
    localparam t_step STEP_SUM_PRESET = 4'd6;
    localparam t_step STEP_CLAMP_PRE  = 4'd7;
    localparam t_step STEP_ZERO       = 4'd8;
    localparam t_step STEP_OUT        = 4'd9;
    localparam t_step STEP_LAST       = STEP_OUT;

    // Multiplier operand selection.
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_ERR_KP,
        MUL_ERR_KI,
        MUL_P1_DT
    } t_mul_sel;

    // Integrator path operation.
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_SUM_INC,
        ACC_SUM_PRESET,
        ACC_CLAMP,
        ACC_ZERO
    } t_acc_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_PRESET,
        COND_KI_ZERO,
        COND_HOLD,
        COND_ALWAYS
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_mul_sel mul;
        logic     ld_prop;
        logic     ld_p1;
        t_acc_op  acc;
        t_cond    cond;
        t_step    target;
        logic     out_ld;
    } t_ctrl_word;

    // Control ROM: the program run for every accepted word.
    function automatic t_ctrl_word ucode_rom(input t_step s);
        t_ctrl_word cw;
        cw = '0;
        unique case (s)
            STEP_MUL_KP: begin
                cw.mul = MUL_ERR_KP;
            end
            STEP_LD_PROP: begin
                cw.ld_prop = 1'b1;
                cw.mul     = MUL_ERR_KI;
                cw.cond    = COND_PRESET;
                cw.target  = STEP_SUM_PRESET;
            end
            STEP_LD_P1: begin
                cw.ld_p1  = 1'b1;
                cw.cond   = COND_KI_ZERO;
                cw.target = STEP_ZERO;
            end
            STEP_MUL_DT: begin
                cw.mul    = MUL_P1_DT;
                cw.cond   = COND_HOLD;
                cw.target = STEP_OUT;
            end
            STEP_SUM_INC: begin
                cw.acc = ACC_SUM_INC;
            end
            STEP_CLAMP_INC: begin
                cw.acc    = ACC_CLAMP;
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_OUT;
            end
            STEP_SUM_PRESET: begin
                cw.acc = ACC_SUM_PRESET;
            end
            STEP_CLAMP_PRE: begin
                cw.acc    = ACC_CLAMP;
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_OUT;
            end
            STEP_ZERO: begin
                cw.acc = ACC_ZERO;
            end
            default: begin
                cw.out_ld = 1'b1;
            end
        endcase
        return cw;
    endfunction

    // Saturate a wide signed value to DATA_WIDTH bits signed.
    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [PROD_W-1:0] x);
        logic hi_any;
        logic hi_all;
        logic signed [DATA_WIDTH-1:0] res;
        hi_any = |x[PROD_W-2:DATA_WIDTH-1];
        hi_all = &x[PROD_W-2:DATA_WIDTH-1];
        priority if (!x[PROD_W-1] && hi_any) begin
            res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (x[PROD_W-1] && !hi_all) begin
            res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            res = x[DATA_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

[sv/piaw_cmd_if.sv]
// Input channel of the PI controller: valid, ready and the command word.
interface piaw_cmd_if import piaw_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [DATA_WIDTH-1:0]  measurement;
    logic signed [DATA_WIDTH-1:0]  setpoint;
    logic [TIME_FRAC-1:0]          time_step;
    logic                          hold_neg;
    logic                          hold_pos;
    logic                          hold_by_sign;
    logic signed [DATA_WIDTH-1:0]  preset_value;

    modport source (
        output valid, op, measurement, setpoint, time_step,
               hold_neg, hold_pos, hold_by_sign, preset_value,
        input  ready
    );

    modport sink (
        input  valid, op, measurement, setpoint, time_step,
               hold_neg, hold_pos, hold_by_sign, preset_value,
        output ready
    );
endinterface

[sv/piaw_res_if.sv]
// Output channel of the PI controller: valid, ready and the result word.
interface piaw_res_if import piaw_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [DATA_WIDTH-1:0]  drive;
    logic signed [DATA_WIDTH-1:0]  prop_term;
    logic signed [DATA_WIDTH-1:0]  integ_value;

    modport source (
        output valid, drive, prop_term, integ_value,
        input  ready
    );

    modport sink (
        input  valid, drive, prop_term, integ_value,
        output ready
    );
endinterface

[sv/pi_controller_antiwindup.sv]
// PI controller with integrator clamp anti-windup, run by a microcoded sequencer.
// An update that adds an increment runs the steps of the control ROM in order; a preset,
// a zero integral gain or a held integrator jumps ahead on a shorter path to the output step.
// A new word is accepted only once the last has left the sequencer; the steps of the
// control ROM share one 33x25 multiplier. The output register frees the input side
// while a result waits. Synchronous active-low reset clears the gains, the limit and
// the integrator; no clearing pass is needed.
module pi_controller_antiwindup
    import piaw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    piaw_cmd_if.sink               i_cmd,
    piaw_res_if.source             o_res
);

    // Configuration registers.
    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [LIM_W-1:0]  r_ilim;

    // Sequencer state.
    logic  r_busy;
    t_step r_step;
    logic  r_out_valid;

    // Captured input word.
    logic                         r_op;
    logic signed [ERR_W-1:0]      r_err;
    logic [TIME_FRAC-1:0]         r_dt;
    logic                         r_hold_neg;
    logic                         r_hold_pos;
    logic                         r_hold_sign;
    logic signed [DATA_WIDTH-1:0] r_preset;

    // Datapath registers.
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [DATA_WIDTH-1:0] r_prop;
    logic signed [DATA_WIDTH-1:0] r_p1;
    logic signed [ERR_W-1:0]      r_sum;
    logic signed [DATA_WIDTH-1:0] r_integ;

    // Output word registers.
    logic signed [DATA_WIDTH-1:0] r_o_drive;
    logic signed [DATA_WIDTH-1:0] r_o_prop;
    logic signed [DATA_WIDTH-1:0] r_o_integ;

    // Combinational signals.
    t_ctrl_word                   w_cw;
    logic                         w_in_fire;
    logic                         w_out_free;
    logic                         w_jump;
    logic                         w_hold;
    logic signed [ERR_W-1:0]      w_ma;
    logic signed [MB_W-1:0]       w_mb;
    logic signed [PROD_W-1:0]     w_shf;
    logic signed [PROD_W-1:0]     w_sht;
    logic signed [DATA_WIDTH-1:0] w_frac_sat;
    logic signed [DATA_WIDTH-1:0] w_inc;
    logic signed [ERR_W-1:0]      w_sum_inc;
    logic signed [ERR_W-1:0]      w_sum_pre;
    logic signed [ERR_W-1:0]      w_drive_sum;
    logic signed [DATA_WIDTH-1:0] w_drive;
    logic signed [CMP_W-1:0]      w_sum_c;
    logic signed [CMP_W-1:0]      w_lim_p;
    logic signed [CMP_W-1:0]      w_lim_n;
    logic signed [CMP_W-1:0]      w_clamped;
    logic signed [CMP_W-1:0]      w_integ_c;
    logic                         w_err_neg;
    logic                         w_err_pos;
    logic                         w_int_neg;
    logic                         w_int_pos;

    // Handshake.
    assign w_in_fire   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_busy;
    assign w_out_free  = !r_out_valid || o_res.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.drive       = r_o_drive;
    assign o_res.prop_term   = r_o_prop;
    assign o_res.integ_value = r_o_integ;

    // Control word of the current step.
    assign w_cw = ucode_rom(r_step);

    // Multiplier operand selection.
    always_comb begin
        unique case (w_cw.mul)
            MUL_ERR_KP: begin
                w_ma = r_err;
                w_mb = MB_W'(r_kp);
            end
            MUL_ERR_KI: begin
                w_ma = r_err;
                w_mb = MB_W'(r_ki);
            end
            MUL_P1_DT: begin
                w_ma = ERR_W'(r_p1);
                w_mb = MB_W'(r_dt);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // Floor shifts and saturation of the product register.
    assign w_shf      = r_prod >>> FRAC_BITS;
    assign w_sht      = r_prod >>> TIME_FRAC;
    assign w_frac_sat = sat_dw(w_shf);
    assign w_inc      = sat_dw(w_sht);

    // Integrator sums and the drive.
    assign w_sum_inc   = ERR_W'(r_integ) + ERR_W'(w_inc);
    assign w_sum_pre   = ERR_W'(r_preset) - ERR_W'(r_prop);
    assign w_drive_sum = ERR_W'(r_prop) + ERR_W'(r_integ);
    assign w_drive     = sat_dw(PROD_W'(w_drive_sum));

    // Clamp of the pending sum to the integrator limit.
    assign w_sum_c   = CMP_W'(r_sum);
    assign w_lim_p   = CMP_W'(r_ilim);
    assign w_lim_n   = -w_lim_p;
    assign w_integ_c = CMP_W'(r_integ);

    always_comb begin
        priority if (w_sum_c > w_lim_p) begin
            w_clamped = w_lim_p;
        end else if (w_sum_c < w_lim_n) begin
            w_clamped = w_lim_n;
        end else begin
            w_clamped = w_sum_c;
        end
    end

    // Hold decision from the error sign and the integrator as it stood before this word.
    assign w_err_neg = r_err[ERR_W-1];
    assign w_err_pos = !r_err[ERR_W-1] && (|r_err);
    assign w_int_neg = r_integ[DATA_WIDTH-1];
    assign w_int_pos = !r_integ[DATA_WIDTH-1] && (|r_integ);
    assign w_hold = ((r_hold_neg || (r_hold_sign && w_int_neg)) && w_err_neg) ||
                    ((r_hold_pos || (r_hold_sign && w_int_pos)) && w_err_pos);

    // Jump condition of the current step.
    always_comb begin
        unique case (w_cw.cond)
            COND_PRESET:  w_jump = (r_op == OP_PRESET);
            COND_KI_ZERO: w_jump = (r_ki == '0);
            COND_HOLD:    w_jump = w_hold;
            COND_ALWAYS:  w_jump = 1'b1;
            default:      w_jump = 1'b0;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_ilim <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:  r_kp   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_ki   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIM:  r_ilim <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_MUL_KP;
        end else if (!r_busy) begin
            if (w_in_fire) begin
                r_busy <= 1'b1;
                r_step <= STEP_MUL_KP;
            end
        end else if (w_cw.out_ld) begin
            if (w_out_free) begin
                r_busy <= 1'b0;
            end
        end else if (w_jump) begin
            r_step <= w_cw.target;
        end else begin
            r_step <= r_step + 1'b1;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_busy && w_cw.out_ld && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Integrator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (r_busy) begin
            unique case (w_cw.acc)
                ACC_CLAMP: r_integ <= sat_dw(PROD_W'(w_clamped));
                ACC_ZERO:  r_integ <= '0;
                default: ;
            endcase
        end
    end

    // Input capture; the error is kept exact at one extra bit.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op        <= i_cmd.op;
            r_err       <= ERR_W'(i_cmd.setpoint) - ERR_W'(i_cmd.measurement);
            r_dt        <= i_cmd.time_step;
            r_hold_neg  <= i_cmd.hold_neg;
            r_hold_pos  <= i_cmd.hold_pos;
            r_hold_sign <= i_cmd.hold_by_sign;
            r_preset    <= i_cmd.preset_value;
        end
    end

    // Shared multiplier and the datapath registers it feeds.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (w_cw.mul != MUL_NONE) begin
                r_prod <= w_ma * w_mb;
            end
            if (w_cw.ld_prop) begin
                r_prop <= w_frac_sat;
            end
            if (w_cw.ld_p1) begin
                r_p1 <= w_frac_sat;
            end
            unique case (w_cw.acc)
                ACC_SUM_INC:    r_sum <= w_sum_inc;
                ACC_SUM_PRESET: r_sum <= w_sum_pre;
                default: ;
            endcase
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (r_busy && w_cw.out_ld && w_out_free) begin
            r_o_drive <= w_drive;
            r_o_prop  <= r_prop;
            r_o_integ <= r_integ;
        end
    end

    // The step counter never leaves the program.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= STEP_LAST))
        else $error("sequencer step outside the control program");

    // An accepted word starts the program at its first step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_busy && (r_step == STEP_MUL_KP)))
        else $error("accepted word did not start the sequencer");

    // After a clamp step the integrator lies within the limit.
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (w_cw.acc == ACC_CLAMP)) |=>
            ((w_integ_c <= w_lim_p) && (w_integ_c >= w_lim_n)))
        else $error("integrator outside its limit after clamp");

    // The final step with a free output register always delivers a result.
    a_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && w_cw.out_ld && w_out_free) |=> (r_out_valid && !r_busy))
        else $error("final step did not deliver a result");

endmodule
